// ===== design/ntgn_pkg.sv =====
`timescale 1ns / 1ps
package ntgn_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam int COORD_W = 20;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int MAG_W   = PROD_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int BIG_W   = 3 * MAG_W;
   localparam int SER_W   = $clog2(MAG_W + 1);
   localparam int HOP_W   = 16;

   localparam logic [2:0] FUNC_UPDATE  = 3'd0;
   localparam logic [2:0] FUNC_REMOVE  = 3'd1;
   localparam logic [2:0] FUNC_PURGE   = 3'd2;
   localparam logic [2:0] FUNC_BEST    = 3'd3;
   localparam logic [2:0] FUNC_AVERAGE = 3'd4;

   localparam logic [1:0] CMP_LT = 2'd0;
   localparam logic [1:0] CMP_EQ = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   typedef struct packed {
      logic [2:0]                func;
      logic [31:0]               node_address;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [31:0]               time_value;
      logic [HOP_W-1:0]          hop_distance;
   } req_type;

   typedef struct packed {
      logic             status;
      logic             found;
      logic [31:0]      best_address;
      logic [HOP_W-1:0] mean_hop_distance;
   } rsp_type;

   typedef struct packed {
      logic                      valid;
      logic [31:0]               address;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_x;
      logic [31:0]               expiry;
      logic [HOP_W-1:0]          hop;
   } entry_type;

endpackage

// ===== design/ntgn_ram.sv =====
`timescale 1ns / 1ps
module ntgn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/neighbor_table_greedy_next_hop_unit.sv =====
`timescale 1ns / 1ps
// Neighbour table with greedy next-hop choice. A transaction is accepted when start is high
// and busy is low; its single result appears on rsp_data for exactly one cycle with rsp_strobe
// high, and the receiver must take it then. The table sits in one memory with a
// registered read, so every valid operation sweeps the table one entry at a time; a function
// code above average finishes without a sweep. Average then runs a bit-serial divider when
// it found entries with a nonzero hop. Best neighbour works on each occupied entry with a
// parallel multiplier, and each candidate that passes the distance test has its dot product
// squared on the shared bit-serial multiplier, with two more products there when its cosine
// must be compared with the current best. After reset the block empties the table one entry
// at a time and holds busy high meanwhile.
module neighbor_table_greedy_next_hop_unit
   import ntgn_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int SUM_W = HOP_W + CNT_W;
   localparam int DIV_W = $clog2(SUM_W + 1);
   localparam int ENT_W = $bits(entry_type);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_EVAL   = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_JUDGE  = 4'd5;
   localparam logic [3:0] S_SER    = 4'd6;
   localparam logic [3:0] S_DECIDE = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   req_type                req_ff, req_in;
   entry_type              ent_ff, ent_in;
   logic [3:0]             step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] my2_ff, my2_in, len2_ff, len2_in;
   logic signed [ACC_W-1:0] dist2_ff, dist2_in, dot_ff, dot_in;
   logic                   hit_ff, hit_in, free_ff, free_in;
   logic [IDX_W-1:0]       hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;
   logic                   have_ff, have_in;
   logic [1:0]             brank_ff, brank_in;
   logic [SQ_W-1:0]        bdot2_ff, bdot2_in, dot2_ff, dot2_in;
   logic [MAG_W-1:0]       blen2_ff, blen2_in, bdist2_ff, bdist2_in;
   logic [31:0]            baddr_ff, baddr_in;
   logic [BIG_W-1:0]       la_ff, la_in, ser_a_ff, ser_a_in, ser_p_ff, ser_p_in;
   logic [MAG_W-1:0]       ser_b_ff, ser_b_in;
   logic [SER_W-1:0]       ser_cnt_ff, ser_cnt_in;
   logic [1:0]             phase_ff, phase_in;
   logic [1:0]             cmp_ff, cmp_in;
   logic [SUM_W-1:0]       sum_ff, sum_in, quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, rem_ff, rem_in;
   logic [DIV_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   logic [ENT_W-1:0]       ram_rdata;
   entry_type              rd_ent;

   logic signed [DIFF_W-1:0] tx, ty, tz, ax, ay, az, ex, ey, ez;
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [ACC_W-1:0]  prod_ext;
   logic                     dot_neg, dot_zero, take, advance;
   logic [1:0]               rank;
   logic [MAG_W-1:0]         dot_mag, len2_u, dist2_u, my2_u;
   logic [CNT_W:0]           div_r;

   ntgn_ram #(
      .WIDTH(ENT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(idx_ff),
      .rd_data(ram_rdata)
   );

   assign rd_ent = entry_type'(ram_rdata);

   always_comb begin
      tx = DIFF_W'(req_ff.point_x) - DIFF_W'(req_ff.origin_x);
      ty = DIFF_W'(req_ff.point_y) - DIFF_W'(req_ff.origin_y);
      tz = DIFF_W'(req_ff.point_z) - DIFF_W'(req_ff.origin_z);
      ax = DIFF_W'(ent_ff.pos_x) - DIFF_W'(req_ff.origin_x);
      ay = DIFF_W'(ent_ff.pos_y) - DIFF_W'(req_ff.origin_y);
      az = DIFF_W'(ent_ff.pos_z) - DIFF_W'(req_ff.origin_z);
      ex = DIFF_W'(req_ff.point_x) - DIFF_W'(ent_ff.pos_x);
      ey = DIFF_W'(req_ff.point_y) - DIFF_W'(ent_ff.pos_y);
      ez = DIFF_W'(req_ff.point_z) - DIFF_W'(ent_ff.pos_z);
      case (step_ff)
         4'd0:    begin mul_a = tx; mul_b = tx; end
         4'd1:    begin mul_a = ty; mul_b = ty; end
         4'd2:    begin mul_a = tz; mul_b = tz; end
         4'd3:    begin mul_a = ax; mul_b = ax; end
         4'd4:    begin mul_a = ay; mul_b = ay; end
         4'd5:    begin mul_a = az; mul_b = az; end
         4'd6:    begin mul_a = ex; mul_b = ex; end
         4'd7:    begin mul_a = ey; mul_b = ey; end
         4'd8:    begin mul_a = ez; mul_b = ez; end
         4'd9:    begin mul_a = tx; mul_b = ax; end
         4'd10:   begin mul_a = ty; mul_b = ay; end
         4'd11:   begin mul_a = tz; mul_b = az; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_ext = ACC_W'(prod_ff);
      dot_neg  = dot_ff[ACC_W-1];
      dot_zero = (dot_ff == '0);
      dot_mag  = dot_neg ? MAG_W'(-dot_ff) : MAG_W'(dot_ff);
      len2_u   = MAG_W'(len2_ff);
      dist2_u  = MAG_W'(dist2_ff);
      my2_u    = MAG_W'(my2_ff);
      rank     = dot_neg ? 2'd0 : (dot_zero ? 2'd1 : 2'd2);
      div_r    = {rem_ff, quo_ff[SUM_W-1]};
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      ent_in        = ent_ff;
      step_in       = step_ff;
      prod_in       = PROD_W'(PROD_W'(mul_a) * PROD_W'(mul_b));
      my2_in        = my2_ff;
      len2_in       = len2_ff;
      dist2_in      = dist2_ff;
      dot_in        = dot_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      have_in       = have_ff;
      brank_in      = brank_ff;
      bdot2_in      = bdot2_ff;
      dot2_in       = dot2_ff;
      blen2_in      = blen2_ff;
      bdist2_in     = bdist2_ff;
      baddr_in      = baddr_ff;
      la_in         = la_ff;
      ser_a_in      = ser_a_ff;
      ser_b_in      = ser_b_ff;
      ser_p_in      = ser_p_ff;
      ser_cnt_in    = ser_cnt_ff;
      phase_in      = phase_ff;
      cmp_in        = cmp_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = rd_ent;
      take          = 1'b0;
      advance       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               have_in  = 1'b0;
               sum_in   = '0;
               cnt_in   = '0;
               state_in = (req_data.func > FUNC_AVERAGE) ? S_FINISH : S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            advance = 1'b1;
            case (req_ff.func)
               FUNC_UPDATE: begin
                  if (rd_ent.valid && rd_ent.address == req_ff.node_address && !hit_ff) begin
                     hit_in      = 1'b1;
                     hit_slot_in = idx_ff;
                  end
                  if (!rd_ent.valid && !free_ff) begin
                     free_in      = 1'b1;
                     free_slot_in = idx_ff;
                  end
               end
               FUNC_REMOVE: begin
                  if (rd_ent.valid && rd_ent.address == req_ff.node_address) begin
                     ram_we          = 1'b1;
                     ram_wdata.valid = 1'b0;
                  end
               end
               FUNC_PURGE: begin
                  if (rd_ent.valid && rd_ent.expiry != '0 &&
                      req_ff.time_value > rd_ent.expiry) begin
                     ram_we          = 1'b1;
                     ram_wdata.valid = 1'b0;
                  end
               end
               FUNC_BEST: begin
                  if (rd_ent.valid) begin
                     advance  = 1'b0;
                     ent_in   = rd_ent;
                     step_in  = '0;
                     my2_in   = '0;
                     len2_in  = '0;
                     dist2_in = '0;
                     dot_in   = '0;
                     state_in = S_MUL;
                  end
               end
               default: begin
                  if (rd_ent.valid && rd_ent.hop != '0) begin
                     sum_in = sum_ff + SUM_W'(rd_ent.hop);
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            endcase
         end
         S_MUL: begin
            step_in = step_ff + 1'b1;
            case (step_ff) inside
               [4'd1:4'd3]:   my2_in   = my2_ff + prod_ext;
               [4'd4:4'd6]:   len2_in  = len2_ff + prod_ext;
               [4'd7:4'd9]:   dist2_in = dist2_ff + prod_ext;
               [4'd10:4'd12]: dot_in   = dot_ff + prod_ext;
               default: ;
            endcase
            if (step_ff == 4'd12) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (len2_u == '0 || dist2_u >= my2_u) begin
               advance = 1'b1;
            end else begin
               phase_in   = 2'd0;
               ser_a_in   = BIG_W'(dot_mag);
               ser_b_in   = dot_mag;
               ser_p_in   = '0;
               ser_cnt_in = '0;
               state_in   = S_SER;
            end
         end
         S_SER: begin
            if (ser_cnt_ff != SER_W'(MAG_W)) begin
               if (ser_b_ff[0]) begin
                  ser_p_in = ser_p_ff + ser_a_ff;
               end
               ser_a_in   = ser_a_ff << 1;
               ser_b_in   = ser_b_ff >> 1;
               ser_cnt_in = ser_cnt_ff + 1'b1;
            end else begin
               ser_p_in   = '0;
               ser_cnt_in = '0;
               case (phase_ff)
                  2'd0: begin
                     dot2_in = SQ_W'(ser_p_ff);
                     if (have_ff && !dot_zero && rank == brank_ff) begin
                        phase_in = 2'd1;
                        ser_a_in = BIG_W'(SQ_W'(ser_p_ff));
                        ser_b_in = blen2_ff;
                     end else begin
                        state_in = S_DECIDE;
                        if (rank > brank_ff) begin
                           cmp_in = CMP_GT;
                        end else if (rank < brank_ff) begin
                           cmp_in = CMP_LT;
                        end else begin
                           cmp_in = CMP_EQ;
                        end
                     end
                  end
                  2'd1: begin
                     la_in    = ser_p_ff;
                     phase_in = 2'd2;
                     ser_a_in = BIG_W'(bdot2_ff);
                     ser_b_in = len2_u;
                  end
                  default: begin
                     state_in = S_DECIDE;
                     if (la_ff == ser_p_ff) begin
                        cmp_in = CMP_EQ;
                     end else if ((la_ff > ser_p_ff) != dot_neg) begin
                        cmp_in = CMP_GT;
                     end else begin
                        cmp_in = CMP_LT;
                     end
                  end
               endcase
            end
         end
         S_DECIDE: begin
            advance = 1'b1;
            take = !have_ff || cmp_ff == CMP_GT ||
                   (cmp_ff == CMP_EQ && (dist2_u < bdist2_ff ||
                    (dist2_u == bdist2_ff && ent_ff.address < baddr_ff)));
            if (take) begin
               have_in   = 1'b1;
               brank_in  = rank;
               bdot2_in  = dot2_ff;
               blen2_in  = len2_u;
               bdist2_in = dist2_u;
               baddr_in  = ent_ff.address;
            end
         end
         S_FINISH: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            case (req_ff.func)
               FUNC_UPDATE: begin
                  if (hit_ff || free_ff) begin
                     ram_we                 = 1'b1;
                     ram_waddr              = hit_ff ? hit_slot_ff : free_slot_ff;
                     ram_wdata.valid        = 1'b1;
                     ram_wdata.address      = req_ff.node_address;
                     ram_wdata.pos_x        = req_ff.point_x;
                     ram_wdata.pos_y        = req_ff.point_y;
                     ram_wdata.pos_z        = req_ff.point_z;
                     ram_wdata.expiry       = req_ff.time_value;
                     ram_wdata.hop          = req_ff.hop_distance;
                  end else begin
                     rsp_in.status = 1'b1;
                  end
               end
               FUNC_BEST: begin
                  rsp_in.found        = have_ff;
                  rsp_in.best_address = have_ff ? baddr_ff : '0;
               end
               FUNC_AVERAGE: begin
                  if (cnt_ff != '0) begin
                     rsp_strobe_in = 1'b0;
                     rem_in        = '0;
                     quo_in        = sum_ff;
                     div_cnt_in    = '0;
                     state_in      = S_DIV;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_cnt_ff == DIV_W'(SUM_W)) begin
               rsp_in                   = '0;
               rsp_in.mean_hop_distance = HOP_W'(quo_ff);
               rsp_strobe_in            = 1'b1;
               state_in                 = S_IDLE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
               if (div_r >= {1'b0, cnt_ff}) begin
                  rem_in = CNT_W'(div_r - {1'b0, cnt_ff});
                  quo_in = {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_in = CNT_W'(div_r);
                  quo_in = {quo_ff[SUM_W-2:0], 1'b0};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_in = S_FINISH;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_READ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff       <= req_in;
      ent_ff       <= ent_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      my2_ff       <= my2_in;
      len2_ff      <= len2_in;
      dist2_ff     <= dist2_in;
      dot_ff       <= dot_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      have_ff      <= have_in;
      brank_ff     <= brank_in;
      bdot2_ff     <= bdot2_in;
      dot2_ff      <= dot2_in;
      blen2_ff     <= blen2_in;
      bdist2_ff    <= bdist2_in;
      baddr_ff     <= baddr_in;
      la_ff        <= la_in;
      ser_a_ff     <= ser_a_in;
      ser_b_ff     <= ser_b_in;
      ser_p_ff     <= ser_p_in;
      ser_cnt_ff   <= ser_cnt_in;
      phase_ff     <= phase_in;
      cmp_ff       <= cmp_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.found |-> rsp_data.mean_hop_distance == '0 && !rsp_data.status)
      else $error("best neighbour result carries stray fields");
endmodule

// ===== test/neighbor_table_greedy_next_hop_checker.sv =====
`timescale 1ns / 1ps
module neighbor_table_greedy_next_hop_checker
   import ntgn_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   logic                      tbl_valid [TABLE_ENTRIES];
   logic [31:0]               tbl_addr  [TABLE_ENTRIES];
   logic signed [COORD_W-1:0] tbl_x     [TABLE_ENTRIES];
   logic signed [COORD_W-1:0] tbl_y     [TABLE_ENTRIES];
   logic signed [COORD_W-1:0] tbl_z     [TABLE_ENTRIES];
   logic [31:0]               tbl_exp   [TABLE_ENTRIES];
   logic [HOP_W-1:0]          tbl_hop   [TABLE_ENTRIES];
   rsp_type                   expected_answers[$];

   function automatic logic [63:0] square_sum(longint a, longint b, longint c);
      return a * a + b * b + c * c;
   endfunction

   // Sign of dot_a/sqrt(la) - dot_b/sqrt(lb), done with wide exact products.
   function automatic int compare_cosine(longint dot_a, logic [63:0] la,
                                         longint dot_b, logic [63:0] lb);
      int          ga;
      int          gb;
      logic [191:0] pa;
      logic [191:0] pb;
      logic [63:0] ma;
      logic [63:0] mb;
      ga = (dot_a > 0) - (dot_a < 0);
      gb = (dot_b > 0) - (dot_b < 0);
      if (ga != gb) return ga > gb ? 1 : -1;
      if (ga == 0) return 0;
      ma = dot_a < 0 ? -dot_a : dot_a;
      mb = dot_b < 0 ? -dot_b : dot_b;
      pa = 192'(ma) * 192'(ma) * 192'(lb);
      pb = 192'(mb) * 192'(mb) * 192'(la);
      if (pa == pb) return 0;
      return ((pa > pb) ? 1 : -1) * ga;
   endfunction

   function automatic rsp_type predict_answer(req_type r);
      rsp_type     a;
      int          slot;
      int          free_slot;
      longint      tx, ty, tz, nx, ny, nz, dot, best_dot;
      logic [63:0] dest2, len2, dist2, best_len2, best_dist2, sum, cnt;
      logic        have;
      int          c;
      a = '0;
      case (r.func)
         FUNC_UPDATE: begin
            slot = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_valid[i] && tbl_addr[i] == r.node_address) begin
                  slot = i;
                  break;
               end
               if (!tbl_valid[i] && free_slot < 0) free_slot = i;
            end
            if (slot < 0) slot = free_slot;
            if (slot < 0) begin
               a.status = 1'b1;
            end else begin
               tbl_valid[slot] = 1'b1;
               tbl_addr[slot] = r.node_address;
               tbl_x[slot] = r.point_x;
               tbl_y[slot] = r.point_y;
               tbl_z[slot] = r.point_z;
               tbl_exp[slot] = r.time_value;
               tbl_hop[slot] = r.hop_distance;
            end
         end
         FUNC_REMOVE: begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (tbl_valid[i] && tbl_addr[i] == r.node_address) tbl_valid[i] = 1'b0;
         end
         FUNC_PURGE: begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (tbl_valid[i] && tbl_exp[i] != 0 && r.time_value > tbl_exp[i])
                  tbl_valid[i] = 1'b0;
         end
         FUNC_BEST: begin
            tx = longint'(r.point_x) - longint'(r.origin_x);
            ty = longint'(r.point_y) - longint'(r.origin_y);
            tz = longint'(r.point_z) - longint'(r.origin_z);
            dest2 = square_sum(tx, ty, tz);
            have = 1'b0;
            best_dot = 0;
            best_len2 = 1;
            best_dist2 = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!tbl_valid[i]) continue;
               nx = longint'(tbl_x[i]) - longint'(r.origin_x);
               ny = longint'(tbl_y[i]) - longint'(r.origin_y);
               nz = longint'(tbl_z[i]) - longint'(r.origin_z);
               len2 = square_sum(nx, ny, nz);
               if (len2 == 0) continue;
               dist2 = square_sum(longint'(r.point_x) - longint'(tbl_x[i]),
                                  longint'(r.point_y) - longint'(tbl_y[i]),
                                  longint'(r.point_z) - longint'(tbl_z[i]));
               if (dist2 >= dest2) continue;
               dot = tx * nx + ty * ny + tz * nz;
               if (have) begin
                  c = compare_cosine(dot, len2, best_dot, best_len2);
                  if (c < 0) continue;
                  if (c == 0) begin
                     if (dist2 > best_dist2) continue;
                     if (dist2 == best_dist2 && tbl_addr[i] >= a.best_address) continue;
                  end
               end
               have = 1'b1;
               best_dot = dot;
               best_len2 = len2;
               best_dist2 = dist2;
               a.best_address = tbl_addr[i];
            end
            a.found = have;
            if (!have) a.best_address = '0;
         end
         FUNC_AVERAGE: begin
            sum = 0;
            cnt = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (tbl_valid[i] && tbl_hop[i] != 0) begin
                  sum += tbl_hop[i];
                  cnt++;
               end
            if (cnt != 0) a.mean_hop_distance = HOP_W'(sum / cnt);
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
         expected_answers.delete();
         failures = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_answers.size() == 0) begin
               $error("Result arrived with no transaction outstanding");
               failures++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  failures++;
               end
               if (rsp_data.best_address !== want.best_address) begin
                  $error("best_address: expected %h, got %h", want.best_address,
                         rsp_data.best_address);
                  failures++;
               end
               if (rsp_data.mean_hop_distance !== want.mean_hop_distance) begin
                  $error("mean_hop_distance: expected %0d, got %0d",
                         want.mean_hop_distance, rsp_data.mean_hop_distance);
                  failures++;
               end
            end
         end
         if (start && !busy) expected_answers.push_back(predict_answer(req_data));
      end
      pending = expected_answers.size();
   end

   initial begin
      failures = 0;
      pending = 0;
   end

endmodule

// ===== test/neighbor_table_greedy_next_hop_unit_test.sv =====
`timescale 1ns / 1ps
module neighbor_table_greedy_next_hop_unit_test;
   import ntgn_pkg::*;

   localparam int ENTRIES = 64;
   localparam int IDLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      issued = 0;
   int      idle_cycles = 0;
   int      op_count[5] = '{default: 0};
   logic [31:0] known_addr[$];

   neighbor_table_greedy_next_hop_unit #(.TABLE_ENTRIES(ENTRIES)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   neighbor_table_greedy_next_hop_checker #(.TABLE_ENTRIES(ENTRIES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .failures(failures), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 20'sh80000;
         1: return 20'sh7FFFF;
         2: return COORD_W'($urandom);
         default: return COORD_W'($signed($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   function automatic logic [31:0] random_address();
      if (known_addr.size() != 0 && $urandom_range(0, 2) != 0)
         return known_addr[$urandom_range(0, known_addr.size() - 1)];
      return $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 90);
   endfunction

   task automatic send(input req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start <= 1'b0;
      issued++;
      if (r.func <= FUNC_AVERAGE) op_count[r.func]++;
      if (r.func == FUNC_UPDATE) known_addr.push_back(r.node_address);
   endtask

   task automatic send_op(input logic [2:0] f, input logic [31:0] a,
                          input logic [31:0] tv, input logic [15:0] hop);
      req_type r;
      r = '0;
      r.func = f;
      r.node_address = a;
      r.point_x = random_coord();
      r.point_y = random_coord();
      r.point_z = random_coord();
      r.origin_x = random_coord();
      r.origin_y = random_coord();
      r.origin_z = random_coord();
      r.time_value = tv;
      r.hop_distance = hop;
      send(r);
   endtask

   initial begin
      req_type r;
      int      burst;
      int      wait_count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_op(FUNC_BEST, 0, 0, 0);
      send_op(FUNC_AVERAGE, 0, 0, 0);
      send_op(FUNC_UPDATE, 32'hFFFF_FFFF, 0, 16'hFFFF);
      send_op(FUNC_UPDATE, 32'h0, 32'hFFFF_FFFF, 16'h0);
      send_op(FUNC_UPDATE, 32'h5, 100, 16'h1);
      send_op(FUNC_UPDATE, 32'h5, 100, 16'h0123);
      r = '0;
      r.func = FUNC_BEST;
      r.point_x = 20'sd5;
      r.origin_x = 20'sd5;
      send(r);
      r.func = FUNC_UPDATE;
      r.node_address = 32'h10;
      r.point_x = 20'sd10;
      send(r);
      r.node_address = 32'h11;
      r.point_y = 20'sd10;
      send(r);
      r.node_address = 32'h12;
      r.point_y = -20'sd10;
      send(r);
      r.func = FUNC_BEST;
      r.point_x = 20'sd100;
      r.point_y = 20'sd0;
      r.origin_x = 20'sd0;
      send(r);
      r.point_x = 20'sd0;
      r.point_y = 20'sd100;
      r.point_z = 20'sd0;
      send(r);
      send_op(FUNC_AVERAGE, 0, 0, 0);
      send_op(FUNC_PURGE, 0, 101, 0);
      send_op(FUNC_PURGE, 0, 32'hFFFF_FFFF, 0);
      send_op(FUNC_REMOVE, 32'h1234_5678, 0, 0);
      send_op(FUNC_REMOVE, 32'h11, 0, 0);
      send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(3'd7, 0, 0, 0);
      for (int i = 0; i < ENTRIES + 2; i++)
         send_op(FUNC_UPDATE, 32'h1000 + i, 0, 16'($urandom_range(0, 800)));
      send_op(FUNC_AVERAGE, 0, 0, 0);
      send_op(FUNC_BEST, 0, 0, 0);
      for (int i = 0; i < ENTRIES; i++) send_op(FUNC_REMOVE, 32'h1000 + i, 0, 0);
      known_addr.delete();

      while (pending != 0) @(negedge clock);

      for (int n = 0; n < 50; n += burst) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_op(FUNC_UPDATE, random_address(), $urandom_range(0, 3) == 0 ?
                                   0 : $urandom, 16'($urandom));
               4: send_op(FUNC_REMOVE, random_address(), 0, 0);
               5: send_op(FUNC_PURGE, 0, $urandom, 0);
               6, 7: send_op(FUNC_BEST, 0, 0, 0);
               8: send_op(FUNC_AVERAGE, 0, 0, 0);
               default: send_op(3'($urandom_range(5, 7)), $urandom, $urandom, 16'($urandom));
            endcase
         end
         if (n > 20 && n < 35) begin
            while (pending != 0) @(negedge clock);
         end
         wait_count = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         repeat (wait_count) @(negedge clock);
      end

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Ran %0d transactions: %0d update, %0d remove, %0d purge, %0d best, %0d average.",
               issued, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
